/* rtl/core/undo_redo_history_ring_macros.svh */
// assertion macros used by the history ring controller rtl
`ifndef UNDO_REDO_HISTORY_RING_MACROS_SVH
`define UNDO_REDO_HISTORY_RING_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define URH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define URH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/urh_pkg.sv */
// shared types, constants and index helpers of the history ring
`default_nettype none

package urh_pkg;

  localparam int MAX_SLOTS   = 64;
  localparam int HANDLE_BITS = 16;
  localparam int SLOT_W      = $clog2(MAX_SLOTS);
  localparam int CNT_W       = $clog2(MAX_SLOTS + 1);
  localparam int CAP_W       = 7;

  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [CAP_W-1:0]       cap_raw_t;
  typedef logic [HANDLE_BITS-1:0] handle_t;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_UNDO  = 2'd1,
    REQ_REDO  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  // one access to the record memory
  typedef struct packed {
    logic    we;
    logic    re;
    slot_t   addr;
    handle_t wdata;
  } mem_req_t;

  // result of one request, minus the handle read from memory
  typedef struct packed {
    logic status;
    logic from_mem;
    cnt_t entry_count;
    logic undo_possible;
    logic redo_possible;
  } rslt_t;

  // clamp a written capacity into 1 .. MAX_SLOTS
  function automatic cnt_t eff_capacity(cap_raw_t raw);
    cnt_t c;
    if (raw == '0) begin
      c = cnt_t'(1);
    end else if (int'(raw) > MAX_SLOTS) begin
      c = cnt_t'(MAX_SLOTS);
    end else begin
      c = cnt_t'(raw);
    end
    return c;
  endfunction

  // physical slot of logical position pos, one conditional subtract
  function automatic slot_t slot_of(slot_t head, cnt_t pos, cnt_t cap);
    logic [CNT_W:0] idx;
    idx = {1'b0, cnt_t'(head)} + {1'b0, pos};
    if (idx >= {1'b0, cap}) begin
      idx = idx - {1'b0, cap};
    end
    if (idx >= (CNT_W + 1)'(MAX_SLOTS)) begin
      idx = '0;
    end
    return idx[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/urh_req_if.sv */
// request channel: valid/ready plus one request word
`default_nettype none

interface urh_req_if;
  import urh_pkg::*;

  logic    valid;
  logic    ready;
  logic [1:0] req_type;
  handle_t record_handle;
  logic    record_valid;

  modport source (output valid, output req_type, output record_handle,
                  output record_valid, input ready);
  modport sink   (input valid, input req_type, input record_handle,
                  input record_valid, output ready);
endinterface

`default_nettype wire

/* rtl/core/urh_rsp_if.sv */
// response channel: valid/ready plus one result word
`default_nettype none

interface urh_rsp_if;
  import urh_pkg::*;

  logic    valid;
  logic    ready;
  logic    status;
  handle_t returned_handle;
  cnt_t    entry_count;
  logic    undo_possible;
  logic    redo_possible;

  modport source (output valid, output status, output returned_handle,
                  output entry_count, output undo_possible, output redo_possible,
                  input ready);
  modport sink   (input valid, input status, input returned_handle,
                  input entry_count, input undo_possible, input redo_possible,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/urh_mem.sv */
// record handle memory, one port, registered read data
`default_nettype none

module urh_mem (
  input  wire logic              clk_i,
  input  wire urh_pkg::mem_req_t mem_i,
  output urh_pkg::handle_t       rdata_o
);
  import urh_pkg::*;

  handle_t store_q [MAX_SLOTS];
  handle_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_i.we) begin
      store_q[mem_i.addr] <= mem_i.wdata;
    end
    if (mem_i.re) begin
      rdata_q <= store_q[mem_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/urh_ctrl.sv */
// pointer registers and request decode of the history ring
`default_nettype none
`include "undo_redo_history_ring_macros.svh"

module urh_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire urh_pkg::cap_raw_t cfg_wdata_i,
  input  wire logic              acc_i,
  input  wire urh_pkg::req_e     req_type_i,
  input  wire urh_pkg::handle_t  handle_i,
  input  wire logic              rec_valid_i,
  output urh_pkg::mem_req_t      mem_o,
  output urh_pkg::rslt_t         rslt_o
);
  import urh_pkg::*;

  cnt_t  cap_q, cap_d;
  slot_t head_q, head_d;
  cnt_t  count_q, count_d;
  cnt_t  cursor_q, cursor_d;

  cnt_t           base_cnt;
  logic [CNT_W:0] head_inc;
  cnt_t           cursor_dec;

  always_comb begin
    cap_d    = cap_q;
    head_d   = head_q;
    count_d  = count_q;
    cursor_d = cursor_q;
    mem_o    = '0;
    rslt_o   = '0;

    base_cnt   = (cursor_q < count_q) ? cursor_q : count_q;
    head_inc   = {1'b0, cnt_t'(head_q)} + (CNT_W + 1)'(1);
    cursor_dec = cursor_q - cnt_t'(1);

    if (cfg_we_i) begin
      cap_d    = eff_capacity(cfg_wdata_i);
      head_d   = '0;
      count_d  = '0;
      cursor_d = '0;
    end else if (acc_i) begin
      unique case (req_type_i)
        REQ_ADD: begin
          if (!rec_valid_i) begin
            rslt_o.status = 1'b1;
          end else begin
            mem_o.we    = 1'b1;
            mem_o.wdata = handle_i;
            if (base_cnt < cap_q) begin
              mem_o.addr = slot_of(head_q, base_cnt, cap_q);
              count_d    = base_cnt + cnt_t'(1);
            end else begin
              // full: overwrite the oldest entry and move the head on
              mem_o.addr = head_q;
              count_d    = base_cnt;
              if (head_inc >= {1'b0, cap_q}) begin
                head_inc = head_inc - {1'b0, cap_q};
              end
              head_d = head_inc[SLOT_W-1:0];
            end
            cursor_d = count_d;
          end
        end
        REQ_UNDO: begin
          if (cursor_q != '0 && count_q != '0) begin
            cursor_d        = cursor_dec;
            mem_o.re        = 1'b1;
            mem_o.addr      = slot_of(head_q, cursor_dec, cap_q);
            rslt_o.from_mem = 1'b1;
          end else begin
            rslt_o.status = 1'b1;
          end
        end
        REQ_REDO: begin
          if (cursor_q < count_q) begin
            mem_o.re        = 1'b1;
            mem_o.addr      = slot_of(head_q, cursor_q, cap_q);
            rslt_o.from_mem = 1'b1;
            cursor_d        = cursor_q + cnt_t'(1);
          end else begin
            rslt_o.status = 1'b1;
          end
        end
        REQ_CLEAR: begin
          head_d   = '0;
          count_d  = '0;
          cursor_d = '0;
        end
      endcase
    end

    rslt_o.entry_count   = count_d;
    rslt_o.undo_possible = (cursor_d != '0) && (count_d != '0);
    rslt_o.redo_possible = cursor_d < count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= cnt_t'(MAX_SLOTS);
      head_q   <= '0;
      count_q  <= '0;
      cursor_q <= '0;
    end else begin
      cap_q    <= cap_d;
      head_q   <= head_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
    end
  end

  `URH_ASSERT_NOW(a_cursor_in_range, 1'b1, cursor_q <= count_q, "cursor above fill count")
  `URH_ASSERT_NOW(a_count_in_range, 1'b1, count_q <= cap_q, "fill count above capacity")
  `URH_ASSERT_NOW(a_head_in_range, 1'b1, cnt_t'(head_q) < cap_q, "head outside ring")
  `URH_ASSERT_NOW(a_one_access, 1'b1, !(mem_o.we && mem_o.re), "read and write together")
  `URH_ASSERT_NEXT(a_add_sets_cursor,
                   acc_i && !cfg_we_i && req_type_i == REQ_ADD && rec_valid_i,
                   cursor_q == count_q && count_q != '0, "add left cursor off the top")

endmodule

`default_nettype wire

/* rtl/core/undo_redo_history_ring.sv */
// top level of the undo/redo history ring: handshake, result register, memory
`default_nettype none

// Undo/redo history ring. Each request word (add, undo, redo, clear) yields
// exactly one result word. A request is taken in the cycle that req_i.valid
// and req_i.ready are both high, and its result shows on rsp_o in the next
// cycle; one request per cycle is sustained as long as results are drained.
// The handles live in a single-port 64-entry memory with a registered read:
// an undo or redo issues its read in the accept cycle and the data lands in
// the memory output register just as the result word becomes valid. An add
// writes the memory in the accept cycle. The head, fill count, cursor and
// capacity sit in flip-flops, so no request waits on another. While a result
// waits for rsp_o.ready the next request is held off, which also keeps the
// memory read data stable for the waiting word. Writing the capacity
// register (cfg_we_i) clamps the value into 1..64 and empties the history.
// After reset the capacity is 64 and the history is empty; no clearing pass.
module undo_redo_history_ring (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire urh_pkg::cap_raw_t cfg_wdata_i,
  urh_req_if.sink                req_i,
  urh_rsp_if.source              rsp_o
);
  import urh_pkg::*;

  logic     acc;
  mem_req_t mem_req;
  rslt_t    rslt;
  handle_t  rdata;

  logic  out_valid_q, out_valid_d;
  rslt_t rslt_q;

  // the result slot frees up when empty or when its word is taken this cycle
  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign acc         = req_i.valid && req_i.ready;

  urh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_i       (acc),
    .req_type_i  (req_e'(req_i.req_type)),
    .handle_i    (req_i.record_handle),
    .rec_valid_i (req_i.record_valid),
    .mem_o       (mem_req),
    .rslt_o      (rslt)
  );

  urh_mem u_mem (
    .clk_i   (clk_i),
    .mem_i   (mem_req),
    .rdata_o (rdata)
  );

  // result word register
  always_comb begin
    out_valid_d = out_valid_q;
    if (acc) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rslt_q <= rslt;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = rslt_q.status;
  // handle comes straight from the memory read register for undo and redo
  assign rsp_o.returned_handle = rslt_q.from_mem ? rdata : '0;
  assign rsp_o.entry_count     = rslt_q.entry_count;
  assign rsp_o.undo_possible   = rslt_q.undo_possible;
  assign rsp_o.redo_possible   = rslt_q.redo_possible;

endmodule

`default_nettype wire
